// ===== design/crcfc_pkg.sv =====
`timescale 1ns / 1ps

package crcfc_pkg;

  localparam int DefMaxFrameLen   = 255;
  localparam int DefMaxPayloadLen = 252;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcMsb  = 16'h8000;

  // Smallest legal frame: eight header bytes, no payload, two CRC bytes.
  localparam int MinFrameLen = 10;

  // Result queue depth; two free slots are needed to take a request.
  localparam int ResQDepth = 4;
  localparam int ResQPtrW  = $clog2(ResQDepth);
  localparam int ResQCntW  = $clog2(ResQDepth + 1);

  typedef enum logic [2:0] {
    StOk         = 3'd0,
    StTooShort   = 3'd1,
    StCrcBad     = 3'd2,
    StPayloadBig = 3'd3,
    StFrameLong  = 3'd4
  } status_e;

  typedef enum logic {
    KindPayload = 1'b0,
    KindVerdict = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic [7:0]  op;
    logic [15:0] subject;
    logic [7:0]  len_byte;
    status_e     status;
    logic        last;
  } result_t;

  // Results produced by one request, first in order before second.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    first;
    result_t    second;
  } push_t;

  // Byte-wide CRC-16 update, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CrcMsb) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== design/crc16_frame_checker.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake                 Payload
// in       request    in_valid_i / in_stall_o   rx_byte_i, frame_end_i
// out      result     out_valid_o / out_stall_i result_kind_o, payload_byte_o,
//                                               message_op_o, message_subject_o,
//                                               message_payload_len_o,
//                                               frame_status_o, last_of_run_o
//
// One request per cycle is taken while in_stall_o is low; its results land in the
// result queue on the same edge and the first can leave on the next cycle.
// A request makes zero, one or two results; the queue drains one per cycle while
// out_stall_i is low, and a frame-ending request with a payload byte makes two.
// in_stall_o rises while fewer than two queue slots are free.
// Reset clears the frame state (CRC to 0xFFFF) and empties the queue.

module crc16_frame_checker #(
  parameter int MAX_FRAME_LEN   = crcfc_pkg::DefMaxFrameLen,
  parameter int MAX_PAYLOAD_LEN = crcfc_pkg::DefMaxPayloadLen
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [7:0]  message_op_o,
  output logic [15:0] message_subject_o,
  output logic [7:0]  message_payload_len_o,
  output logic [2:0]  frame_status_o,
  output logic        last_of_run_o
);
  import crcfc_pkg::*;

  logic    accept;
  logic    full;
  push_t   push;
  result_t head;

  // Take a request only when the queue can absorb its worst case.
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  // Delay line, CRC and header capture.
  crcfc_frame #(
    .MAX_FRAME_LEN  (MAX_FRAME_LEN),
    .MAX_PAYLOAD_LEN(MAX_PAYLOAD_LEN)
  ) u_frame (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .rx_byte_i  (rx_byte_i),
    .frame_end_i(frame_end_i),
    .push_o     (push)
  );

  // Result queue parts the two sides; the head holds while stalled.
  crcfc_resq u_resq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (!out_stall_i),
    .full_o (full),
    .valid_o(out_valid_o),
    .head_o (head)
  );

  assign result_kind_o         = head.kind;
  assign payload_byte_o        = head.payload_byte;
  assign message_op_o          = head.op;
  assign message_subject_o     = head.subject;
  assign message_payload_len_o = head.len_byte;
  assign frame_status_o        = head.status;
  assign last_of_run_o         = head.last;

endmodule

// ===== design/crcfc_frame.sv =====
`timescale 1ns / 1ps

module crcfc_frame #(
  parameter int MAX_FRAME_LEN   = crcfc_pkg::DefMaxFrameLen,
  parameter int MAX_PAYLOAD_LEN = crcfc_pkg::DefMaxPayloadLen
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      rx_byte_i,
  input  logic            frame_end_i,
  output crcfc_pkg::push_t push_o
);
  import crcfc_pkg::*;

  localparam logic [8:0] MaxFrame   = 9'(MAX_FRAME_LEN);
  localparam logic [7:0] MaxPayload = 8'(MAX_PAYLOAD_LEN);
  localparam logic [8:0] MinLess1   = 9'(MinFrameLen - 1);

  logic [7:0]  dly0_q, dly1_q;
  logic [8:0]  pos_q, pos_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  op_q, op_d;
  logic [15:0] subj_q, subj_d;
  logic [7:0]  plen_q, plen_d;
  logic [7:0]  emitted_q, emitted_d;

  logic [8:0] old_pos;
  logic       emit;
  status_e    status;
  result_t    pay_res, ver_res;

  assign old_pos = pos_q - 9'd2;

  always_comb begin
    crc_d     = crc_q;
    op_d      = op_q;
    subj_d    = subj_q;
    plen_d    = plen_q;
    emitted_d = emitted_q;
    emit      = 1'b0;
    if (pos_q >= 9'd2) begin
      crc_d = crc_byte(crc_q, dly0_q);
      case (old_pos)
        9'd0: op_d = dly0_q;
        9'd3: subj_d = {dly0_q, subj_q[7:0]};
        9'd4: subj_d = {subj_q[15:8], dly0_q};
        9'd7: plen_d = dly0_q;
        default: begin
          if (old_pos >= 9'd8 && plen_q <= MaxPayload && emitted_q < plen_q) begin
            emit      = 1'b1;
            emitted_d = emitted_q + 8'd1;
          end
        end
      endcase
    end
  end

  // Status priority: short, long, CRC, payload length.
  always_comb begin
    if (pos_q < MinLess1) begin
      status = StTooShort;
    end else if (pos_q >= MaxFrame) begin
      status = StFrameLong;
    end else if (crc_d != {dly1_q, rx_byte_i}) begin
      status = StCrcBad;
    end else if (plen_d > MaxPayload) begin
      status = StPayloadBig;
    end else begin
      status = StOk;
    end
  end

  always_comb begin
    pay_res              = '0;
    pay_res.kind         = KindPayload;
    pay_res.payload_byte = dly0_q;
    pay_res.status       = StOk;
    ver_res              = '0;
    ver_res.kind         = KindVerdict;
    ver_res.op           = op_d;
    ver_res.subject      = subj_d;
    ver_res.len_byte     = plen_d;
    ver_res.status       = status;
    ver_res.last         = 1'b1;
  end

  always_comb begin
    push_o = '0;
    if (accept_i) begin
      if (emit) begin
        push_o.first  = pay_res;
        push_o.second = ver_res;
        push_o.cnt    = frame_end_i ? 2'd2 : 2'd1;
      end else if (frame_end_i) begin
        push_o.first = ver_res;
        push_o.cnt   = 2'd1;
      end
    end
  end

  assign pos_d = (pos_q == 9'h1FF) ? pos_q : pos_q + 9'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dly0_q    <= '0;
      dly1_q    <= '0;
      pos_q     <= '0;
      crc_q     <= CrcInit;
      op_q      <= '0;
      subj_q    <= '0;
      plen_q    <= '0;
      emitted_q <= '0;
    end else if (accept_i) begin
      if (frame_end_i) begin
        dly0_q    <= '0;
        dly1_q    <= '0;
        pos_q     <= '0;
        crc_q     <= CrcInit;
        op_q      <= '0;
        subj_q    <= '0;
        plen_q    <= '0;
        emitted_q <= '0;
      end else begin
        dly0_q    <= dly1_q;
        dly1_q    <= rx_byte_i;
        pos_q     <= pos_d;
        crc_q     <= crc_d;
        op_q      <= op_d;
        subj_q    <= subj_d;
        plen_q    <= plen_d;
        emitted_q <= emitted_d;
      end
    end
  end

  // Never emit more payload bytes than the header announced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emitted_q <= plen_q || emitted_q == 8'd0)
    else $error("payload emitted count exceeds length");

  // A verdict is always the last result of its request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && frame_end_i) |->
      ((push_o.cnt == 2'd1 && push_o.first.last) ||
       (push_o.cnt == 2'd2 && push_o.second.last && !push_o.first.last)))
    else $error("verdict missing from end-of-frame push");

  // Frame state restarts after each verdict.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && frame_end_i) |=> (pos_q == 9'd0 && crc_q == CrcInit))
    else $error("frame state not cleared after verdict");

endmodule

// ===== design/crcfc_resq.sv =====
`timescale 1ns / 1ps

module crcfc_resq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  crcfc_pkg::push_t   push_i,
  input  logic               pop_i,
  output logic               full_o,
  output logic               valid_o,
  output crcfc_pkg::result_t head_o
);
  import crcfc_pkg::*;

  result_t               mem_q [ResQDepth];
  logic [ResQPtrW-1:0]   wr_ptr_q, rd_ptr_q, wr_ptr1;
  logic [ResQCntW-1:0]   cnt_q, cnt_d;
  logic                  pop;

  assign pop     = pop_i && valid_o;
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_ptr_q];
  // Hold off new requests unless two slots are free.
  assign full_o  = cnt_q > ResQCntW'(ResQDepth - 2);
  assign wr_ptr1 = wr_ptr_q + ResQPtrW'(1);
  assign cnt_d   = cnt_q + ResQCntW'(push_i.cnt) - ResQCntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr1] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + ResQPtrW'(push_i.cnt);
      rd_ptr_q <= rd_ptr_q + ResQPtrW'(pop);
      cnt_q    <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ResQCntW'(ResQDepth))
    else $error("result queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt != 2'd0) |-> !full_o)
    else $error("push into queue without room");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_i.cnt == 2'd0) |=> cnt_q == $past(cnt_q) - ResQCntW'(1))
    else $error("queue count did not drop on pop");

endmodule
